// ----- sv/wsp_pkg.sv -----
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared widths, register indexes and pipeline types for the world-to-screen
// projection block.
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam int COEF_W    = 24;
    localparam int CFG_W     = 2 * COEF_W;
    localparam int POS_W     = 32;
    localparam int DIM_W     = 13;
    localparam int SCR_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_LANES = 3;

    // A 24 x 32 signed product.
    localparam int PROD_W = COEF_W + POS_W;
    // Three products plus the scaled constant term.
    localparam int CLIP_W = PROD_W + 2;
    localparam int NUM_W  = CLIP_W + 1;
    localparam int DEN_W  = CLIP_W + 1;
    // The numerator is multiplied by the viewport size in two halves.
    localparam int SPLIT  = 30;
    localparam int PL_W   = DIM_W + SPLIT;
    localparam int PH_W   = DIM_W + 1 + NUM_W - SPLIT;
    localparam int MUL_W  = DIM_W + NUM_W;
    localparam int DIV_STEPS = SCR_W;
    localparam int REM_W  = DEN_W + DIV_STEPS - 1;
    localparam int CMP_W  = REM_W + 1;
    localparam int BIAS_SHIFT = 16;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

    localparam logic signed [SCR_W-1:0] SCR_MAX = {1'b0, {(SCR_W-1){1'b1}}};
    localparam logic signed [SCR_W-1:0] SCR_MIN = {1'b1, {(SCR_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_W_XY     = 3'd0,
        REG_W_ZB     = 3'd1,
        REG_X_XY     = 3'd2,
        REG_X_ZB     = 3'd3,
        REG_Y_XY     = 3'd4,
        REG_Y_ZB     = 3'd5,
        REG_WIDTH    = 3'd6,
        REG_HEIGHT   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [SCR_W-1:0] quo;
        logic             sat_hi;
        logic             sat_lo;
    } div_lane_t;

    typedef struct packed {
        logic             vis;
        logic [DEN_W-1:0] den;
        div_lane_t        lx;
        div_lane_t        ly;
    } div_stage_t;

    // One restoring division step against the denominator shifted by sh.
    function automatic div_lane_t div_step(div_lane_t a, logic [DEN_W-1:0] den,
                                           int unsigned sh);
        div_lane_t        r;
        logic [REM_W-1:0] dk;
        r  = a;
        dk = REM_W'(den) << sh;
        if (a.rem >= dk)
        begin
            r.rem = a.rem - dk;
            r.quo = {a.quo[SCR_W-2:0], 1'b1};
        end
        else
        begin
            r.quo = {a.quo[SCR_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ----- sv/wsp_if.sv -----
// ----------------------------------------------------------------------------
// wsp_in_if / wsp_out_if
// Valid-ready channels for world points and projected screen points.
// ----------------------------------------------------------------------------
interface wsp_in_if import wsp_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface wsp_out_if import wsp_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    visible;
    logic signed [SCR_W-1:0] screen_x;
    logic signed [SCR_W-1:0] screen_y;

    modport source (output valid, output visible, output screen_x, output screen_y,
                    input ready);
    modport sink   (input valid, input visible, input screen_x, input screen_y,
                    output ready);
endinterface

// ----- sv/world_to_screen_projection.sv -----
// An accepted point passes through the product, clip, numerator, scaling, saturation, divider and output registers.
// One point per cycle while the output is not stalled; the divider is unrolled into 16 register stages.
// Each stage advances whenever it is empty or its successor advances, so bubbles close up.
// Reset clears all valid bits; coefficients reset to zero, viewport to 1920 x 1080.
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Affine clip transform, perspective divide and viewport mapping with
// exact floor and 16-bit saturation.
// ----------------------------------------------------------------------------
module world_to_screen_projection import wsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    wsp_in_if.sink               in_ch,
    wsp_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int NSTG    = DIV_STEPS + 7;
    localparam int S_DIV0  = 6;

    // Configuration registers.
    logic [CFG_W-1:0] coef_xy_reg [NUM_LANES];
    logic [CFG_W-1:0] coef_zb_reg [NUM_LANES];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                coef_xy_reg[i] <= '0;
                coef_zb_reg[i] <= '0;
            end
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_idx))
                REG_W_XY:   coef_xy_reg[0] <= cfg_data;
                REG_W_ZB:   coef_zb_reg[0] <= cfg_data;
                REG_X_XY:   coef_xy_reg[1] <= cfg_data;
                REG_X_ZB:   coef_zb_reg[1] <= cfg_data;
                REG_Y_XY:   coef_xy_reg[2] <= cfg_data;
                REG_Y_ZB:   coef_zb_reg[2] <= cfg_data;
                REG_WIDTH:  width_reg      <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg     <= cfg_data[DIM_W-1:0];
                default:    width_reg      <= width_reg;
            endcase
        end
    end

    // Stage valid bits and the advance chain.
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || out_ch.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_ch.valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign in_ch.ready = en[0];

    // Stage 0: the nine coefficient products.
    logic signed [PROD_W-1:0] prod_reg [3*NUM_LANES];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                prod_reg[3*l]   <= $signed(coef_xy_reg[l][COEF_W-1:0]) * in_ch.pos_x;
                prod_reg[3*l+1] <= $signed(coef_xy_reg[l][CFG_W-1:COEF_W]) * in_ch.pos_y;
                prod_reg[3*l+2] <= $signed(coef_zb_reg[l][COEF_W-1:0]) * in_ch.pos_z;
            end
        end
    end

    // Stage 1: clip w, x and y.
    logic signed [CLIP_W-1:0] clip_reg [NUM_LANES];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                clip_reg[l] <= CLIP_W'(prod_reg[3*l]) + CLIP_W'(prod_reg[3*l+1])
                             + CLIP_W'(prod_reg[3*l+2])
                             + (CLIP_W'($signed(coef_zb_reg[l][CFG_W-1:COEF_W]))
                                <<< BIAS_SHIFT);
            end
        end
    end

    // Stage 2: numerators and the common denominator 2w.
    logic                    vis2_reg;
    logic signed [NUM_W-1:0] nx2_reg;
    logic signed [NUM_W-1:0] ny2_reg;
    logic [DEN_W-1:0]        den2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            vis2_reg <= clip_reg[0] > 0;
            nx2_reg  <= NUM_W'(clip_reg[1]) + NUM_W'(clip_reg[0]);
            ny2_reg  <= NUM_W'(clip_reg[0]) - NUM_W'(clip_reg[2]);
            den2_reg <= {clip_reg[0], 1'b0};
        end
    end

    // Stage 3: numerator times viewport size, as two partial products.
    logic                   vis3_reg;
    logic [DEN_W-1:0]       den3_reg;
    logic [PL_W-1:0]        plx_reg;
    logic [PL_W-1:0]        ply_reg;
    logic signed [PH_W-1:0] phx_reg;
    logic signed [PH_W-1:0] phy_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            vis3_reg <= vis2_reg;
            den3_reg <= den2_reg;
            plx_reg  <= PL_W'(width_reg) * PL_W'(nx2_reg[SPLIT-1:0]);
            ply_reg  <= PL_W'(height_reg) * PL_W'(ny2_reg[SPLIT-1:0]);
            phx_reg  <= $signed({1'b0, width_reg}) * $signed(nx2_reg[NUM_W-1:SPLIT]);
            phy_reg  <= $signed({1'b0, height_reg}) * $signed(ny2_reg[NUM_W-1:SPLIT]);
        end
    end

    // Stage 4: full scaled numerators.
    logic                    vis4_reg;
    logic [DEN_W-1:0]        den4_reg;
    logic signed [MUL_W-1:0] mx4_reg;
    logic signed [MUL_W-1:0] my4_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            vis4_reg <= vis3_reg;
            den4_reg <= den3_reg;
            mx4_reg  <= (MUL_W'(phx_reg) <<< SPLIT) + $signed(MUL_W'(plx_reg));
            my4_reg  <= (MUL_W'(phy_reg) <<< SPLIT) + $signed(MUL_W'(ply_reg));
        end
    end

    // Stage 5: saturation checks. An in-range quotient is offset by 2^15 so
    // that the divider sees a non-negative dividend below 2^16 times the divisor.
    div_stage_t div_reg [DIV_STEPS+1];
    logic signed [CMP_W-1:0] dsh_s;
    logic signed [CMP_W-1:0] mx_ext;
    logic signed [CMP_W-1:0] my_ext;
    div_stage_t div_in;

    always_comb
    begin
        dsh_s  = $signed({1'b0, REM_W'(den4_reg) << (SCR_W - 1)});
        mx_ext = CMP_W'(mx4_reg);
        my_ext = CMP_W'(my4_reg);
        div_in.vis       = vis4_reg;
        div_in.den       = den4_reg;
        div_in.lx.sat_hi = mx_ext >= dsh_s;
        div_in.lx.sat_lo = mx_ext < -dsh_s;
        div_in.lx.rem    = REM_W'(mx_ext + dsh_s);
        div_in.lx.quo    = '0;
        div_in.ly.sat_hi = my_ext >= dsh_s;
        div_in.ly.sat_lo = my_ext < -dsh_s;
        div_in.ly.rem    = REM_W'(my_ext + dsh_s);
        div_in.ly.quo    = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[S_DIV0-1])
        begin
            div_reg[0] <= div_in;
        end
    end

    // Stages 6 to 21: one quotient bit per stage, most significant first.
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en[S_DIV0+j])
            begin
                div_reg[j+1].vis <= div_reg[j].vis;
                div_reg[j+1].den <= div_reg[j].den;
                div_reg[j+1].lx  <= div_step(div_reg[j].lx, div_reg[j].den,
                                             DIV_STEPS - 1 - j);
                div_reg[j+1].ly  <= div_step(div_reg[j].ly, div_reg[j].den,
                                             DIV_STEPS - 1 - j);
            end
        end
    end

    // Stage 22: output register.
    logic                    vis_out_reg;
    logic signed [SCR_W-1:0] sx_out_reg;
    logic signed [SCR_W-1:0] sy_out_reg;
    logic signed [SCR_W-1:0] sx_next;
    logic signed [SCR_W-1:0] sy_next;

    always_comb
    begin
        if (!div_reg[DIV_STEPS].vis)
        begin
            sx_next = '0;
            sy_next = '0;
        end
        else
        begin
            if (div_reg[DIV_STEPS].lx.sat_hi)
                sx_next = SCR_MAX;
            else if (div_reg[DIV_STEPS].lx.sat_lo)
                sx_next = SCR_MIN;
            else
                sx_next = {~div_reg[DIV_STEPS].lx.quo[SCR_W-1],
                           div_reg[DIV_STEPS].lx.quo[SCR_W-2:0]};
            if (div_reg[DIV_STEPS].ly.sat_hi)
                sy_next = SCR_MAX;
            else if (div_reg[DIV_STEPS].ly.sat_lo)
                sy_next = SCR_MIN;
            else
                sy_next = {~div_reg[DIV_STEPS].ly.quo[SCR_W-1],
                           div_reg[DIV_STEPS].ly.quo[SCR_W-2:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTG-1])
        begin
            vis_out_reg <= div_reg[DIV_STEPS].vis;
            sx_out_reg  <= sx_next;
            sy_out_reg  <= sy_next;
        end
    end

    assign out_ch.valid    = v_reg[NSTG-1];
    assign out_ch.visible  = vis_out_reg;
    assign out_ch.screen_x = sx_out_reg;
    assign out_ch.screen_y = sy_out_reg;

endmodule

// ----- sv/wsp_checker.sv -----
// ----------------------------------------------------------------------------
// wsp_checker
// Port-level checks on the projection block's channels.
// ----------------------------------------------------------------------------
module wsp_checker import wsp_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    out_visible,
    input logic signed [SCR_W-1:0] out_screen_x,
    input logic signed [SCR_W-1:0] out_screen_y
);

    // A waiting output transaction is held until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped under stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_screen_x) && $stable(out_screen_y)
                                    && $stable(out_visible))
    else $error("output payload changed under stall");

    // The pipeline only pushes back when the output register is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
    else $error("input stalled while output stage can advance");

    // A point behind the viewer reports the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_visible |-> out_screen_x == 0 && out_screen_y == 0)
    else $error("invisible point with nonzero coordinates");

endmodule

bind world_to_screen_projection wsp_checker u_wsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_visible  (out_ch.visible),
    .out_screen_x (out_ch.screen_x),
    .out_screen_y (out_ch.screen_y)
);
